// File: hdl/bhs_pkg.sv
// Shared types, constants and helper functions of the bilinear heightmap sampler.
`default_nettype none

package bhs_pkg;

	// Store geometry and field widths.
	localparam int MAX_TEXELS = 65536;
	localparam int ADDR_W     = $clog2(MAX_TEXELS);
	localparam int MAX_DIM    = 4096;
	localparam int DIM_W      = 13;
	localparam int IDX_W      = $clog2(MAX_DIM);
	localparam int FRAC_W     = 16;
	localparam int HEIGHT_W   = 16;
	localparam int COORD_W    = 18;
	localparam int CLAMP_W    = COORD_W - 1;
	localparam int POS_W      = CLAMP_W + DIM_W;
	localparam int IB_W       = POS_W - FRAC_W;

	// Coordinate constants with 16 fraction bits: COORD_ONE in Q1.16, COORD_HALF in Q14.16.
	localparam logic [CLAMP_W-1:0] COORD_ONE  = CLAMP_W'(65536);
	localparam logic [POS_W-1:0]   COORD_HALF = POS_W'(32768);

	// Configuration port.
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_MAP_WIDTH  = 1'b0;
	localparam logic REG_MAP_HEIGHT = 1'b1;
	localparam logic [DIM_W-1:0] SIZE_RESET = DIM_W'(256);

	// Input operation codes.
	typedef enum logic {
		OP_WRITE  = 1'b0,
		OP_SAMPLE = 1'b1
	} op_t;

	// One axis resolved into a lower and an upper index, both clamped to the map border, and a fraction.
	typedef struct packed {
		logic [IDX_W-1:0]  i0;
		logic [IDX_W-1:0]  i1;
		logic [FRAC_W-1:0] frac;
	} axis_t;

	// A size of zero acts as one, and anything above the maximum as the maximum.
	function automatic logic [DIM_W-1:0] eff_size(input logic [DIM_W-1:0] r);
		logic [DIM_W-1:0] s;
		if (r == '0) begin
			s = DIM_W'(1);
		end else if (r > DIM_W'(MAX_DIM)) begin
			s = DIM_W'(MAX_DIM);
		end else begin
			s = r;
		end
		return s;
	endfunction

	// Clamp a signed coordinate to the range 0 to 1.0.
	function automatic logic [CLAMP_W-1:0] clamp_coord(input logic signed [COORD_W-1:0] c);
		logic [CLAMP_W-1:0] r;
		if (c < 0) begin
			r = '0;
		end else if (c > $signed({1'b0, COORD_ONE})) begin
			r = COORD_ONE;
		end else begin
			r = c[CLAMP_W-1:0];
		end
		return r;
	endfunction

	// Split a scaled position (texel coordinate plus one) into indices and fraction.
	function automatic axis_t split_axis(input logic [POS_W-1:0] p,
			input logic [DIM_W-1:0] s);
		logic [IB_W-1:0] ib1;
		logic [IB_W-1:0] ib0;
		logic [IB_W-1:0] last;
		axis_t a;
		ib1 = p[POS_W-1:FRAC_W];
		ib0 = ib1 - IB_W'(1);
		last = IB_W'(s) - IB_W'(1);
		a.frac = p[FRAC_W-1:0];
		if (ib1 == '0) begin
			a.i0 = '0;
		end else if (ib0 > last) begin
			a.i0 = last[IDX_W-1:0];
		end else begin
			a.i0 = ib0[IDX_W-1:0];
		end
		if (ib1 > last) begin
			a.i1 = last[IDX_W-1:0];
		end else begin
			a.i1 = ib1[IDX_W-1:0];
		end
		return a;
	endfunction

endpackage

`default_nettype wire

// File: hdl/bilinear_heightmap_sampler.sv
// Top level of the bilinear heightmap sampler: texel store and sampling pipeline.
`default_nettype none

// Usage:
// An input transaction is accepted on a rising edge with start high; busy is
// always low, so a transaction may be issued in every cycle. operation selects
// a texel write (texel_address, texel_value) or a sample at (coord_u, coord_v).
// A write gives no result. A sample gives one result: done and sampled_height
// are driven from the last pipeline register. Throughput is one transaction
// per cycle. The seven stages are the coordinate scale multiply, the index
// split, the row address multiply, the store read, the horizontal lerps, the
// vertical lerp multiply and the final rounding. The store is kept twice, one
// copy for the upper and one for the lower texel row, each with two read
// ports; every write goes to both copies. map_width and map_height are to be
// written over the APB port only while the block is idle, which the block
// itself does not enforce; both reset to 256. Reset clears the pipeline valid
// bits and the size registers but not the store, whose entries must be
// written before use. The receiver cannot stall; results are never held back.
module bilinear_heightmap_sampler (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic                                operation,
	input  wire logic [bhs_pkg::ADDR_W-1:0]          texel_address,
	input  wire logic [bhs_pkg::HEIGHT_W-1:0]        texel_value,
	input  wire logic signed [bhs_pkg::COORD_W-1:0]  coord_u,
	input  wire logic signed [bhs_pkg::COORD_W-1:0]  coord_v,
	output logic                                     done,
	output logic [bhs_pkg::HEIGHT_W-1:0]             sampled_height,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [bhs_pkg::PADDR_W-1:0]         paddr,
	input  wire logic [bhs_pkg::PDATA_W-1:0]         pwdata,
	output logic [bhs_pkg::PDATA_W-1:0]              prdata,
	output logic                                     pready
);
	import bhs_pkg::*;

	localparam int LERP_W = HEIGHT_W + FRAC_W;
	localparam int ROW_W  = IDX_W + DIM_W;
	localparam int HP_W   = 2 * (HEIGHT_W + 1);
	localparam int VD_W   = LERP_W + 2;
	localparam int VP_W   = VD_W + FRAC_W + 1;

	logic [DIM_W-1:0] width_q, height_q;
	logic [DIM_W-1:0] w_eff, h_eff;
	logic             cfg_wr;

	// Stage registers.
	logic                   v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	op_t                    op_s1, op_s2, op_s3;
	logic [ADDR_W-1:0]      waddr_s1, waddr_s2, waddr_s3;
	logic [HEIGHT_W-1:0]    wdata_s1, wdata_s2, wdata_s3;
	logic [POS_W-1:0]       pu_s1, pv_s1;
	axis_t                  ax_s2, ay_s2;
	logic [ADDR_W-1:0]      i00_s3, i01_s3, i10_s3, i11_s3;
	logic [FRAC_W-1:0]      fx_s3, fy_s3, fx_s4, fy_s4, fy_s5;
	logic [HEIGHT_W-1:0]    t00_s4, t01_s4, t10_s4, t11_s4;
	logic [LERP_W-1:0]      top_s5, bot_s5, top_s6;
	logic signed [VP_W-1:0] vprod_s6;
	logic [HEIGHT_W-1:0]    result_s7;

	// Memories: upper-row copy and lower-row copy of the store.
	logic [HEIGHT_W-1:0] mem_top_q [MAX_TEXELS];
	logic [HEIGHT_W-1:0] mem_bot_q [MAX_TEXELS];

	// Combinational stage logic.
	logic [CLAMP_W-1:0]      cu, cv;
	logic [POS_W-1:0]        pu, pv;
	axis_t                   ax, ay;
	logic [ROW_W-1:0]        row0, row1;
	logic                    mem_wr;
	logic signed [HEIGHT_W:0] dtop, dbot;
	logic signed [HP_W-1:0]  ptop, pbot;
	logic [LERP_W-1:0]       top, bot;
	logic signed [VD_W-1:0]  vdiff;
	logic signed [VP_W-1:0]  vprod;
	logic signed [VP_W-1:0]  vsum;

	// The pipeline never stalls.
	assign busy = 1'b0;

	// Configuration registers over APB.
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;
	assign prdata = (paddr[2] == REG_MAP_HEIGHT) ? PDATA_W'(height_q) : PDATA_W'(width_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIZE_RESET;
			height_q <= SIZE_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_MAP_WIDTH) begin
				width_q <= pwdata[DIM_W-1:0];
			end else begin
				height_q <= pwdata[DIM_W-1:0];
			end
		end
	end

	assign w_eff = eff_size(width_q);
	assign h_eff = eff_size(height_q);

	// Stage 1: clamp the coordinates and scale them to texel space plus one.
	always_comb begin
		cu = clamp_coord(coord_u);
		cv = clamp_coord(coord_v);
		pu = POS_W'(cu) * POS_W'(w_eff) + COORD_HALF;
		pv = POS_W'(cv) * POS_W'(h_eff) + COORD_HALF;
	end

	// Stage 2: split each axis into edge-clamped indices and a fraction.
	assign ax = split_axis(pu_s1, w_eff);
	assign ay = split_axis(pv_s1, h_eff);

	// Stage 3: linear addresses of the four neighbors, wrapped to the store size.
	always_comb begin
		row0 = ROW_W'(ay_s2.i0) * ROW_W'(w_eff);
		row1 = ROW_W'(ay_s2.i1) * ROW_W'(w_eff);
	end

	// Stage 5: horizontal lerps as t0 plus the difference scaled by the fraction.
	always_comb begin
		dtop = $signed({1'b0, t01_s4}) - $signed({1'b0, t00_s4});
		dbot = $signed({1'b0, t11_s4}) - $signed({1'b0, t10_s4});
		ptop = HP_W'(dtop) * HP_W'($signed({1'b0, fx_s4}));
		pbot = HP_W'(dbot) * HP_W'($signed({1'b0, fx_s4}));
		top  = LERP_W'($signed({2'b00, t00_s4, {FRAC_W{1'b0}}}) + ptop);
		bot  = LERP_W'($signed({2'b00, t10_s4, {FRAC_W{1'b0}}}) + pbot);
	end

	// Stage 6: vertical difference times the vertical fraction.
	always_comb begin
		vdiff = $signed({2'b00, bot_s5}) - $signed({2'b00, top_s5});
		vprod = VP_W'(vdiff) * VP_W'($signed({1'b0, fy_s5}));
	end

	// Stage 7: add the upper row back and round half up.
	always_comb begin
		vsum = $signed(VP_W'({top_s6, {FRAC_W{1'b0}}})) + vprod_s6
			+ $signed(VP_W'({1'b1, {(2 * FRAC_W - 1){1'b0}}}));
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3 && (op_s3 == OP_SAMPLE);
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// Pipeline payload.
	always_ff @(posedge clk) begin
		op_s1    <= op_t'(operation);
		waddr_s1 <= texel_address;
		wdata_s1 <= texel_value;
		pu_s1    <= pu;
		pv_s1    <= pv;

		op_s2    <= op_s1;
		waddr_s2 <= waddr_s1;
		wdata_s2 <= wdata_s1;
		ax_s2    <= ax;
		ay_s2    <= ay;

		op_s3    <= op_s2;
		waddr_s3 <= waddr_s2;
		wdata_s3 <= wdata_s2;
		i00_s3   <= row0[ADDR_W-1:0] + ADDR_W'(ax_s2.i0);
		i01_s3   <= row0[ADDR_W-1:0] + ADDR_W'(ax_s2.i1);
		i10_s3   <= row1[ADDR_W-1:0] + ADDR_W'(ax_s2.i0);
		i11_s3   <= row1[ADDR_W-1:0] + ADDR_W'(ax_s2.i1);
		fx_s3    <= ax_s2.frac;
		fy_s3    <= ay_s2.frac;

		fx_s4    <= fx_s3;
		fy_s4    <= fy_s3;

		top_s5   <= top;
		bot_s5   <= bot;
		fy_s5    <= fy_s4;

		top_s6   <= top_s5;
		vprod_s6 <= vprod;

		result_s7 <= vsum[2 * FRAC_W +: HEIGHT_W];
	end

	// Store writes happen in the same stage as the reads, keeping transaction order.
	assign mem_wr = v_s3 && (op_s3 == OP_WRITE);

	always_ff @(posedge clk) begin
		if (mem_wr) begin
			mem_top_q[waddr_s3] <= wdata_s3;
		end
		t00_s4 <= mem_top_q[i00_s3];
		t01_s4 <= mem_top_q[i01_s3];
	end

	always_ff @(posedge clk) begin
		if (mem_wr) begin
			mem_bot_q[waddr_s3] <= wdata_s3;
		end
		t10_s4 <= mem_bot_q[i10_s3];
		t11_s4 <= mem_bot_q[i11_s3];
	end

	assign done           = v_s7;
	assign sampled_height = result_s7;

endmodule

`default_nettype wire

// File: tb/sv/bilinear_heightmap_sampler_tb.sv
// Self-checking testbench for the bilinear heightmap sampler: texel writes, samples and size registers.
module bilinear_heightmap_sampler_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bhs_pkg::*;

	// Seven pipeline stages from the accepting edge to the result strobe.
	localparam int PIPE_LATENCY   = 7;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int STORE_DEPTH    = MAX_TEXELS;
	localparam logic [PADDR_W-1:0] MAP_WIDTH_ADDR  = {REG_MAP_WIDTH, 2'b00};
	localparam logic [PADDR_W-1:0] MAP_HEIGHT_ADDR = {REG_MAP_HEIGHT, 2'b00};

	// One command transaction as seen on the input ports.
	typedef struct {
		op_t                        op;
		logic [ADDR_W-1:0]          addr;
		logic [HEIGHT_W-1:0]        value;
		logic signed [COORD_W-1:0]  u;
		logic signed [COORD_W-1:0]  v;
	} heightmap_txn_t;

	// One axis of a sample: neighbor indices and the blend fraction.
	typedef struct {
		int unsigned      lo;
		int unsigned      hi;
		longint unsigned  frac;
	} axis_split_t;

	logic                       clk;
	logic                       arst_n;
	logic                       start;
	logic                       busy;
	logic                       operation;
	logic [ADDR_W-1:0]          texel_address;
	logic [HEIGHT_W-1:0]        texel_value;
	logic signed [COORD_W-1:0]  coord_u;
	logic signed [COORD_W-1:0]  coord_v;
	logic                       done;
	logic [HEIGHT_W-1:0]        sampled_height;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [PADDR_W-1:0]         paddr;
	logic [PDATA_W-1:0]         pwdata;
	logic [PDATA_W-1:0]         prdata;
	logic                       pready;

	// Shadow of the texel store, the size registers and the pending samples.
	logic [HEIGHT_W-1:0]  height_shadow [STORE_DEPTH];
	bit                   texel_written [STORE_DEPTH];
	logic [DIM_W-1:0]     map_width_reg;
	logic [DIM_W-1:0]     map_height_reg;
	logic [HEIGHT_W-1:0]  expected_heights [$];
	int                   failures;
	bit                   idling_on;

	bilinear_heightmap_sampler dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.operation      (operation),
		.texel_address  (texel_address),
		.texel_value    (texel_value),
		.coord_u        (coord_u),
		.coord_v        (coord_v),
		.done           (done),
		.sampled_height (sampled_height),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// A size of zero acts as one; anything above the maximum acts as the maximum.
	function automatic int unsigned effective_size(input logic [DIM_W-1:0] r);
		if (r == '0) begin
			return 1;
		end else if (r > MAX_DIM) begin
			return MAX_DIM;
		end
		return 32'(r);
	endfunction

	// Clamp a coordinate to 0..1.0, scale it and split it into clamped indices.
	function automatic axis_split_t split_coord(input logic signed [COORD_W-1:0] c,
			input int unsigned size);
		longint unsigned pos;
		longint unsigned ib1;
		longint unsigned last;
		axis_split_t a;
		if (c < 0) begin
			pos = 0;
		end else if (c > 65536) begin
			pos = 65536;
		end else begin
			pos = longint'(c);
		end
		pos = pos * size + 32768;
		ib1 = pos >> 16;
		a.frac = pos & 64'hFFFF;
		last = size - 1;
		if (ib1 == 0) begin
			a.lo = 0;
		end else if (ib1 - 1 > last) begin
			a.lo = 32'(last);
		end else begin
			a.lo = 32'(ib1 - 1);
		end
		a.hi = (ib1 > last) ? 32'(last) : 32'(ib1);
		return a;
	endfunction

	// Linear store index; rows beyond the store wrap around.
	function automatic int unsigned store_index(input int unsigned x, input int unsigned y,
			input int unsigned w);
		longint unsigned idx;
		idx = (longint'(y) * w + x) % STORE_DEPTH;
		return 32'(idx);
	endfunction

	// Expected height: two horizontal blends, one vertical, rounded half up.
	function automatic logic [HEIGHT_W-1:0] predict_height(input logic signed [COORD_W-1:0] u,
			input logic signed [COORD_W-1:0] v);
		int unsigned w;
		int unsigned h;
		axis_split_t ax;
		axis_split_t ay;
		longint unsigned one;
		longint unsigned top;
		longint unsigned bot;
		longint unsigned r;
		w = effective_size(map_width_reg);
		h = effective_size(map_height_reg);
		ax = split_coord(u, w);
		ay = split_coord(v, h);
		one = 64'd1 << FRAC_W;
		top = height_shadow[store_index(ax.lo, ay.lo, w)] * (one - ax.frac)
			+ height_shadow[store_index(ax.hi, ay.lo, w)] * ax.frac;
		bot = height_shadow[store_index(ax.lo, ay.hi, w)] * (one - ax.frac)
			+ height_shadow[store_index(ax.hi, ay.hi, w)] * ax.frac;
		r = top * (one - ay.frac) + bot * ay.frac;
		r = (r + (64'd1 << (2 * FRAC_W - 1))) >> (2 * FRAC_W);
		if (r > 64'hFFFF) begin
			r = 64'hFFFF;
		end
		return r[HEIGHT_W-1:0];
	endfunction

	// Coordinates: mostly inside 0..1.0, some right at the borders, some anywhere.
	function automatic logic signed [COORD_W-1:0] random_coord();
		logic signed [COORD_W-1:0] c;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: begin
				c = COORD_W'($urandom_range(0, 65536));
			end
			6: begin
				case ($urandom_range(0, 5))
					0: c = COORD_W'(0);
					1: c = COORD_W'(1);
					2: c = COORD_W'(65535);
					3: c = COORD_W'(65536);
					4: c = COORD_W'(65537);
					default: c = COORD_W'(-1);
				endcase
			end
			default: begin
				c = COORD_W'($urandom);
			end
		endcase
		return c;
	endfunction

	// Drive one transaction, after a random idle gap if idling is on, wait for it to be taken and update the shadow state.
	task automatic send_transaction(input heightmap_txn_t t);
		int gap;
		if (idling_on && $urandom_range(0, 2) == 0) begin
			gap = $urandom_range(1, 7);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start         <= 1'b1;
		operation     <= t.op;
		texel_address <= t.addr;
		texel_value   <= t.value;
		coord_u       <= t.u;
		coord_v       <= t.v;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (t.op == OP_WRITE) begin
			height_shadow[t.addr] = t.value;
			texel_written[t.addr] = 1'b1;
		end else begin
			expected_heights.push_back(predict_height(t.u, t.v));
		end
	endtask

	task automatic write_texel(input logic [ADDR_W-1:0] addr, input logic [HEIGHT_W-1:0] value);
		heightmap_txn_t t;
		t.op    = OP_WRITE;
		t.addr  = addr;
		t.value = value;
		t.u     = COORD_W'($urandom);
		t.v     = COORD_W'($urandom);
		send_transaction(t);
	endtask

	// Sample, first filling any of the four neighbors that was never written.
	task automatic sample_at(input logic signed [COORD_W-1:0] u,
			input logic signed [COORD_W-1:0] v);
		int unsigned w;
		int unsigned idx [4];
		axis_split_t ax;
		axis_split_t ay;
		heightmap_txn_t t;
		w = effective_size(map_width_reg);
		ax = split_coord(u, w);
		ay = split_coord(v, effective_size(map_height_reg));
		idx[0] = store_index(ax.lo, ay.lo, w);
		idx[1] = store_index(ax.hi, ay.lo, w);
		idx[2] = store_index(ax.lo, ay.hi, w);
		idx[3] = store_index(ax.hi, ay.hi, w);
		foreach (idx[k]) begin
			if (!texel_written[idx[k]]) begin
				write_texel(ADDR_W'(idx[k]), HEIGHT_W'($urandom));
			end
		end
		t.op    = OP_SAMPLE;
		t.addr  = ADDR_W'($urandom);
		t.value = HEIGHT_W'($urandom);
		t.u     = u;
		t.v     = v;
		send_transaction(t);
	endtask

	// Let every pending sample come back and the pipeline run empty.
	task automatic wait_idle();
		start <= 1'b0;
		while (expected_heights.size() != 0) @(posedge clk);
		repeat (PIPE_LATENCY + 3) @(posedge clk);
	endtask

	task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (addr == MAP_WIDTH_ADDR) begin
			map_width_reg = data[DIM_W-1:0];
		end else if (addr == MAP_HEIGHT_ADDR) begin
			map_height_reg = data[DIM_W-1:0];
		end
		@(posedge clk);
	endtask

	task automatic apb_read(input logic [PADDR_W-1:0] addr, output logic [PDATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		data = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_register(input logic [PADDR_W-1:0] addr, input string name,
			input logic [DIM_W-1:0] want);
		logic [PDATA_W-1:0] got;
		apb_read(addr, got);
		if (got !== PDATA_W'(want)) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			failures++;
		end
	endtask

	// Resize the map; the block must be idle first.
	task automatic set_map_size(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
		wait_idle();
		apb_write(MAP_WIDTH_ADDR, PDATA_W'(w));
		apb_write(MAP_HEIGHT_ADDR, PDATA_W'(h));
	endtask

	// Reset values, then extreme values written and read back on both registers.
	task automatic test_register_access();
		logic [DIM_W-1:0] vals [4];
		vals = '{DIM_W'(0), DIM_W'(8191), DIM_W'(MAX_DIM), DIM_W'(1)};
		check_register(MAP_WIDTH_ADDR, "map_width", SIZE_RESET);
		check_register(MAP_HEIGHT_ADDR, "map_height", SIZE_RESET);
		foreach (vals[k]) begin
			apb_write(MAP_WIDTH_ADDR, PDATA_W'(vals[k]));
			apb_write(MAP_HEIGHT_ADDR, PDATA_W'(vals[3 - k]));
			check_register(MAP_WIDTH_ADDR, "map_width", vals[k]);
			check_register(MAP_HEIGHT_ADDR, "map_height", vals[3 - k]);
		end
	endtask

	// A 2x2 map with extreme heights, corners, clamped and half-way coordinates.
	task automatic test_corner_samples();
		set_map_size(DIM_W'(2), DIM_W'(2));
		write_texel(0, 16'd0);
		write_texel(1, 16'd1);
		write_texel(2, 16'hFFFF);
		write_texel(3, 16'hFFFE);
		sample_at(0, 0);
		sample_at(65536, 65536);
		sample_at(-131072, 131071);
		sample_at(131071, -1);
		sample_at(32768, 0);
		sample_at(32768, 32768);
		sample_at(16384, 49152);
	endtask

	// Sizes of zero collapse the map to a single texel.
	task automatic test_zero_size();
		set_map_size(DIM_W'(0), DIM_W'(0));
		sample_at(12345, 65536);
	endtask

	// Oversized and full-size maps: reads past the store wrap around.
	task automatic test_store_wraparound();
		set_map_size(DIM_W'(8191), DIM_W'(MAX_DIM));
		write_texel(16'hFFFF, 16'hFFFF);
		write_texel(16'h0000, 16'h0000);
		sample_at(65536, 65536);
		sample_at(0, 0);
		sample_at(-5, 131071);
	endtask

	// Random mix of writes and samples on one map size.
	task automatic run_phase(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
			input int count, input bit allow_idle);
		longint unsigned region;
		logic [HEIGHT_W-1:0] value;
		set_map_size(w, h);
		region = longint'(effective_size(w)) * effective_size(h);
		if (region > STORE_DEPTH) begin
			region = STORE_DEPTH;
		end
		for (int i = 0; i < count; i++) begin
			if (i % 32 == 0) begin
				idling_on = allow_idle && ($urandom_range(0, 3) != 0);
			end
			if ($urandom_range(0, 9) < 6) begin
				sample_at(random_coord(), random_coord());
			end else begin
				case ($urandom_range(0, 7))
					0: value = '0;
					1: value = '1;
					default: value = HEIGHT_W'($urandom);
				endcase
				if ($urandom_range(0, 3) != 0) begin
					write_texel(ADDR_W'($urandom_range(0, 32'(region - 1))), value);
				end else begin
					write_texel(ADDR_W'($urandom), value);
				end
			end
		end
	endtask

	task automatic test_random_sizes();
		run_phase(DIM_W'(4), DIM_W'(4), 80, 1'b1);
		run_phase(DIM_W'(1), DIM_W'(MAX_DIM), 50, 1'b1);
		run_phase(DIM_W'(MAX_DIM), DIM_W'(1), 50, 1'b1);
		run_phase(DIM_W'(0), DIM_W'(5), 40, 1'b1);
		run_phase(DIM_W'(8191), DIM_W'(8191), 60, 1'b1);
		run_phase(DIM_W'(17), DIM_W'(9), 80, 1'b1);
		run_phase(DIM_W'($urandom_range(1, 64)), DIM_W'($urandom_range(1, 64)), 60, 1'b1);
		run_phase(DIM_W'($urandom_range(1, MAX_DIM)), DIM_W'($urandom_range(1, MAX_DIM)),
			50, 1'b1);
		run_phase(DIM_W'(256), DIM_W'(256), 50, 1'b1);
	endtask

	// Closing stretch: one transaction per cycle, no gaps.
	task automatic test_back_to_back();
		run_phase(DIM_W'(300), DIM_W'(200), 100, 1'b0);
	endtask

	// Every result strobe is compared with the oldest pending sample.
	always @(posedge clk) begin
		logic [HEIGHT_W-1:0] want;
		if (arst_n && done) begin
			if (expected_heights.size() == 0) begin
				$error("sampled_height with no sample pending: actual %0d", sampled_height);
				failures++;
			end else begin
				want = expected_heights.pop_front();
				if (sampled_height !== want) begin
					$error("sampled_height mismatch: expected %0d, actual %0d",
						want, sampled_height);
					failures++;
				end
			end
		end
	end

	// Ends the run when no transaction moves for too long.
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("== FAIL ==");
		$finish;
	end

	// Reset, then the tests in turn, then the verdict.
	initial begin : main
		failures       = 0;
		idling_on      = 1'b1;
		map_width_reg  = SIZE_RESET;
		map_height_reg = SIZE_RESET;
		arst_n        <= 1'b0;
		start         <= 1'b0;
		operation     <= OP_WRITE;
		texel_address <= '0;
		texel_value   <= '0;
		coord_u       <= '0;
		coord_v       <= '0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_register_access();
		test_corner_samples();
		test_zero_size();
		test_store_wraparound();
		test_random_sizes();
		test_back_to_back();
		wait_idle();
		if (failures == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// File: sim.f
hdl/bhs_pkg.sv
hdl/bilinear_heightmap_sampler.sv
tb/sv/bilinear_heightmap_sampler_tb.sv
